/* src/ckar_pkg.sv */
// Shared constants, types and helpers for the color key alpha replacement block.
// Used by every module under src; depends on nothing else.
package ckar_pkg;

  // Hue angle resolution of the trig path, in bits per full turn.
  localparam int TRIG_BITS = 12;
  // Left shift that turns a quarter-wave fraction into a Q16 argument.
  localparam int QUARTER_SHIFT = 18 - TRIG_BITS;
  // Hue is kept in sixths of a turn, Q16; the angle index drops this many low bits.
  localparam int HUE_DROP = 17 - TRIG_BITS;

  // Divider geometry: 24-bit dividend, 8-bit divisor, 3 quotient bits a stage.
  localparam int DIV_W      = 24;
  localparam int DEN_W      = 8;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  // Register stages of the cosine unit and of the whole color-to-cone path.
  localparam int COS_LAT  = 7;
  localparam int CONE_LAT = 1 + DIV_STAGES + 2 + COS_LAT + 2;

  // Distance space codes.
  localparam logic [1:0] MODE_RGB = 2'd0;
  localparam logic [1:0] MODE_HSV = 2'd1;
  localparam logic [1:0] MODE_HSL = 2'd2;
  localparam logic [1:0] MODE_OFF = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_RED   = 3'd1;
  localparam logic [2:0] REG_GREEN = 3'd2;
  localparam logic [2:0] REG_BLUE  = 3'd3;
  localparam logic [2:0] REG_TOL   = 3'd4;
  localparam logic [2:0] REG_ALPHA = 3'd5;

  // A color as a point on the cone: chroma plane and axis.
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [15:0]        z;
  } cone_pt_t;

  // Difference of two channels scaled to Q0.16.
  function automatic logic signed [18:0] chan_diff(input logic [7:0] a, input logic [7:0] b);
    logic signed [18:0] da;
    logic signed [18:0] db;
    da = $signed({11'b0, a});
    db = $signed({11'b0, b});
    return (da - db) * 19'sd257;
  endfunction

endpackage

/* src/ckar_div.sv */
// Pipelined restoring divider, three quotient bits per register stage.
// Depends on ckar_pkg for its widths.
module ckar_div import ckar_pkg::*; (
  input  logic             clk,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [DIV_W-1:0] quo
);

  // Each stage holds the dividend bits still to go, with quotient bits shifted in.
  logic [DIV_W-1:0] work      [DIV_STAGES];
  logic [DEN_W:0]   rem       [DIV_STAGES];
  logic [DEN_W-1:0] dvs       [DIV_STAGES];
  logic [DIV_W-1:0] work_next [DIV_STAGES];
  logic [DEN_W:0]   rem_next  [DIV_STAGES];
  logic [DIV_W-1:0] cw;
  logic [DEN_W:0]   cr;
  logic [DEN_W-1:0] cd;

  // Shift-subtract steps of every stage.
  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        cw = num;
        cr = '0;
        cd = den;
      end else begin
        cw = work[s-1];
        cr = rem[s-1];
        cd = dvs[s-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        cr = {cr[DEN_W-1:0], cw[DIV_W-1]};
        if (cr >= {1'b0, cd}) begin
          cr = cr - {1'b0, cd};
          cw = {cw[DIV_W-2:0], 1'b1};
        end else begin
          cw = {cw[DIV_W-2:0], 1'b0};
        end
      end
      work_next[s] = cw;
      rem_next[s]  = cr;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      work[s] <= work_next[s];
      rem[s]  <= rem_next[s];
      dvs[s]  <= (s == 0) ? den : dvs[(s == 0) ? 0 : s-1];
    end
  end

  assign quo = work[DIV_STAGES-1];

endmodule

/* src/ckar_cos.sv */
// Pipelined quarter-wave polynomial cosine, signed Q1.15 result.
// Depends on ckar_pkg for the angle width and the quarter-wave shift.
module ckar_cos import ckar_pkg::*; (
  input  logic                 clk,
  input  logic [TRIG_BITS-1:0] ang,
  output logic signed [15:0]   val
);

  logic [1:0]  q1, q2, q3, q4, q5, q6;
  logic [16:0] u1, u0;
  logic [16:0] u2_2, u2_3, u2_4, u2_5, u2_6;
  logic [5:0]  p1;
  logic [10:0] p2;
  logic [14:0] p3;
  logic [16:0] p4;
  logic [33:0] sq_u;
  logic [22:0] m2;
  logic [27:0] m3;
  logic [31:0] m4;
  logic [33:0] m5;
  logic signed [19:0] rv;
  logic [15:0] rr;

  // Fold the angle into the first quadrant.
  always_comb begin
    u0 = 17'(ang[TRIG_BITS-3:0]) << QUARTER_SHIFT;
    if (ang[TRIG_BITS-2]) begin
      u0 = 17'd65536 - u0;
    end
  end

  // Horner steps of the polynomial, at most one multiply per stage.
  assign sq_u = u1 * u1;
  assign m2   = p1 * u2_3;
  assign m3   = p2 * u2_4;
  assign m4   = p3 * u2_5;
  assign m5   = p4 * u2_6;

  // Final stage: subtract, round to Q1.15, clamp and apply the quadrant sign.
  always_comb begin
    rv = 20'sd65536 - $signed({2'b0, m5[33:16]});
    if (rv < 0) begin
      rv = '0;
    end
    rr = 16'((rv + 20'sd1) >>> 1);
    if (rr > 16'd32767) begin
      rr = 16'd32767;
    end
  end

  always_ff @(posedge clk) begin
    u1   <= u0;
    q1   <= ang[TRIG_BITS-1:TRIG_BITS-2];
    u2_2 <= sq_u[32:16];
    q2   <= q1;
    p1   <= 6'd60 - {4'b0, u2_2[16:15]};
    u2_3 <= u2_2;
    q3   <= q2;
    p2   <= 11'd1367 - {4'b0, m2[22:16]};
    u2_4 <= u2_3;
    q4   <= q3;
    p3   <= 15'd16624 - {3'b0, m3[27:16]};
    u2_5 <= u2_4;
    q5   <= q4;
    p4   <= 17'd80853 - {1'b0, m4[31:16]};
    u2_6 <= u2_5;
    q6   <= q5;
    if (q6 == 2'd1 || q6 == 2'd2) begin
      val <= -$signed(rr);
    end else begin
      val <= $signed(rr);
    end
  end

endmodule

/* src/ckar_cone.sv */
// Color-to-cone pipeline: saturation, hue, trig and chroma coordinates.
// Depends on ckar_pkg, ckar_div and ckar_cos.
module ckar_cone import ckar_pkg::*; (
  input  logic       clk,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       hsl,
  output cone_pt_t   pt
);

  logic [7:0]  mx, mn, dl, mag;
  logic [1:0]  sec;
  logic signed [8:0] diff;
  logic [8:0]  sm;
  logic [16:0] sm257;
  logic [15:0] z0;
  logic [7:0]  sden;

  logic [DIV_W-1:0] s1_snum, s1_hnum;
  logic [DEN_W-1:0] s1_sden, s1_hden;
  logic [1:0]  s1_sec;
  logic        s1_neg, s1_ach;
  logic [15:0] s1_z;

  logic [DIV_W-1:0] squo, hquo;
  logic [1:0]  sd_sec [DIV_STAGES];
  logic        sd_neg [DIV_STAGES];
  logic        sd_ach [DIV_STAGES];
  logic [15:0] sd_z   [DIV_STAGES];

  logic signed [20:0] hs;
  logic [18:0] h1_h;
  logic [15:0] h1_sat, h1_z;
  logic        h1_ach;

  logic [TRIG_BITS+1:0]  tdiv;
  logic [TRIG_BITS+19:0] tprod;
  logic [TRIG_BITS-1:0]  h2_ang, sang;
  logic [15:0] h2_sat, h2_z;
  logic        h2_ach;

  logic [15:0] cd_sat [COS_LAT];
  logic        cd_ach [COS_LAT];
  logic [15:0] cd_z   [COS_LAT];
  logic signed [15:0] cv, sv;
  logic [14:0] cmag, smag;

  logic [30:0] sc_px, sc_py;
  logic        sc_nx, sc_ny, sc_ach;
  logic [15:0] sc_z;
  logic [16:0] rx, ry;

  // Extremes, sector and divider operands, on 8-bit channels since 257 cancels.
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dl = mx - mn;
    if (mx == red) begin
      sec  = 2'd0;
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (mx == green) begin
      sec  = 2'd1;
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec  = 2'd2;
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    mag   = diff[8] ? 8'(-diff) : diff[7:0];
    sm    = {1'b0, mx} + {1'b0, mn};
    sm257 = {sm, 8'b0} + {8'b0, sm};
    z0    = hsl ? sm257[16:1] : {mx, mx};
    if (!hsl) begin
      sden = mx;
    end else if (sm <= 9'd255) begin
      sden = sm[7:0];
    end else begin
      sden = 8'(9'd510 - sm);
    end
  end

  always_ff @(posedge clk) begin
    s1_snum <= {dl, 16'b0} - {16'b0, dl};
    s1_sden <= sden;
    s1_hnum <= {mag, 16'b0};
    s1_hden <= dl;
    s1_sec  <= sec;
    s1_neg  <= diff[8];
    s1_ach  <= (dl == 8'd0);
    s1_z    <= z0;
  end

  ckar_div u_sat_div (.clk(clk), .num(s1_snum), .den(s1_sden), .quo(squo));
  ckar_div u_hue_div (.clk(clk), .num(s1_hnum), .den(s1_hden), .quo(hquo));

  // Side data that rides along with the dividers.
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        sd_sec[s] <= s1_sec;
        sd_neg[s] <= s1_neg;
        sd_ach[s] <= s1_ach;
        sd_z[s]   <= s1_z;
      end else begin
        sd_sec[s] <= sd_sec[s-1];
        sd_neg[s] <= sd_neg[s-1];
        sd_ach[s] <= sd_ach[s-1];
        sd_z[s]   <= sd_z[s-1];
      end
    end
  end

  // Hue in sixths of a turn, wrapped into one turn.
  always_comb begin
    hs = $signed({4'b0, hquo[16:0]});
    if (sd_neg[DIV_STAGES-1]) begin
      hs = -hs;
    end
    hs = hs + $signed({2'b0, sd_sec[DIV_STAGES-1], 17'b0});
    if (hs < 0) begin
      hs = hs + 21'sd393216;
    end else if (hs >= 21'sd393216) begin
      hs = hs - 21'sd393216;
    end
  end

  always_ff @(posedge clk) begin
    h1_h   <= hs[18:0];
    h1_sat <= squo[15:0];
    h1_ach <= sd_ach[DIV_STAGES-1];
    h1_z   <= sd_z[DIV_STAGES-1];
  end

  // Angle index: drop low hue bits, then divide by three with a reciprocal.
  assign tdiv  = h1_h[18:HUE_DROP];
  assign tprod = tdiv * 18'd174763;

  always_ff @(posedge clk) begin
    h2_ang <= tprod[19 +: TRIG_BITS];
    h2_sat <= h1_sat;
    h2_ach <= h1_ach;
    h2_z   <= h1_z;
  end

  assign sang = h2_ang - TRIG_BITS'(1 << (TRIG_BITS - 2));

  ckar_cos u_cos (.clk(clk), .ang(h2_ang), .val(cv));
  ckar_cos u_sin (.clk(clk), .ang(sang), .val(sv));

  always_ff @(posedge clk) begin
    for (int s = 0; s < COS_LAT; s++) begin
      if (s == 0) begin
        cd_sat[s] <= h2_sat;
        cd_ach[s] <= h2_ach;
        cd_z[s]   <= h2_z;
      end else begin
        cd_sat[s] <= cd_sat[s-1];
        cd_ach[s] <= cd_ach[s-1];
        cd_z[s]   <= cd_z[s-1];
      end
    end
  end

  // Scale the trig values by saturation, on magnitudes.
  assign cmag = cv[15] ? 15'(-cv) : cv[14:0];
  assign smag = sv[15] ? 15'(-sv) : sv[14:0];

  always_ff @(posedge clk) begin
    sc_px  <= cd_sat[COS_LAT-1] * cmag;
    sc_py  <= cd_sat[COS_LAT-1] * smag;
    sc_nx  <= cv[15];
    sc_ny  <= sv[15];
    sc_ach <= cd_ach[COS_LAT-1];
    sc_z   <= cd_z[COS_LAT-1];
  end

  // Round half up in magnitude, then restore the sign; gray sits on the axis.
  assign rx = 17'((32'(sc_px) + 32'd16384) >> 15);
  assign ry = 17'((32'(sc_py) + 32'd16384) >> 15);

  always_ff @(posedge clk) begin
    if (sc_ach) begin
      pt.x <= '0;
      pt.y <= '0;
    end else begin
      pt.x <= sc_nx ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
      pt.y <= sc_ny ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
    end
    pt.z <= sc_z;
  end

endmodule

/* src/color_key_alpha_replace.sv */
// Top level of the color key alpha replacement block: registers, pipeline, compare.
// Depends on ckar_pkg and ckar_cone.
//
// One RGBA pixel is taken per clock whenever start is high; busy never rises, so the
// block sustains one pixel per cycle. Each result appears on the output ports for one
// cycle with done high. Between a pixel and its result lie the input register, the
// color-to-cone pipeline (a 24-bit divider at three bits a stage, the seven-stage
// cosine polynomial and the saturation scaling) and three distance and compare stages.
// Results cannot be held off, so the receiver must take every one as it comes. The key
// color runs through its own copy of the cone pipeline beside each pixel, so
// configuration may be written whenever no pixel is in flight.
module color_key_alpha_replace import ckar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  input  logic [7:0]  pixel_alpha,
  output logic        done,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        matched,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TOTAL_LAT = CONE_LAT + 4;

  logic [1:0]  color_mode;
  logic [7:0]  key_red, key_green, key_blue, new_alpha;
  logic [16:0] tolerance_q16;
  logic [2:0]  reg_index;
  logic        wr;
  logic [33:0] tol2;
  logic [36:0] limit;

  logic       e_vld;
  logic [7:0] e_r, e_g, e_b, e_a;
  logic       dly_vld [CONE_LAT];
  logic [7:0] dly_r [CONE_LAT];
  logic [7:0] dly_g [CONE_LAT];
  logic [7:0] dly_b [CONE_LAT];
  logic [7:0] dly_a [CONE_LAT];

  cone_pt_t ppt, kpt;
  logic       is_hsl;

  logic       d1_vld;
  logic signed [18:0] d1_dx, d1_dy, d1_dz;
  logic [7:0] d1_r, d1_g, d1_b, d1_a;
  logic signed [37:0] px2, py2, pz2;
  logic       d2_vld;
  logic [35:0] d2_sx, d2_sy, d2_sz;
  logic [7:0] d2_r, d2_g, d2_b, d2_a;
  logic [36:0] dist_sum;
  logic       hit;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr        = psel && penable && pwrite;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode    <= MODE_RGB;
      key_red       <= '0;
      key_green     <= '0;
      key_blue      <= '0;
      tolerance_q16 <= '0;
      new_alpha     <= '0;
    end else if (wr) begin
      case (reg_index)
        REG_MODE:  color_mode    <= pwdata[1:0];
        REG_RED:   key_red       <= pwdata[7:0];
        REG_GREEN: key_green     <= pwdata[7:0];
        REG_BLUE:  key_blue      <= pwdata[7:0];
        REG_TOL:   tolerance_q16 <= pwdata[16:0];
        REG_ALPHA: new_alpha     <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_index)
      REG_MODE:  prdata = {30'b0, color_mode};
      REG_RED:   prdata = {24'b0, key_red};
      REG_GREEN: prdata = {24'b0, key_green};
      REG_BLUE:  prdata = {24'b0, key_blue};
      REG_TOL:   prdata = {15'b0, tolerance_q16};
      REG_ALPHA: prdata = {24'b0, new_alpha};
      default:   prdata = '0;
    endcase
  end

  // Threshold: tolerance squared, times three for RGB and four for the cone spaces.
  always_ff @(posedge clk) begin
    tol2 <= tolerance_q16 * tolerance_q16;
    if (color_mode == MODE_RGB) begin
      limit <= {2'b0, tol2, 1'b0} + {3'b0, tol2};
    end else begin
      limit <= {1'b0, tol2, 2'b0};
    end
  end

  // Input register: one transaction is taken each cycle that start is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= start && !busy;
    end
    e_r <= pixel_red;
    e_g <= pixel_green;
    e_b <= pixel_blue;
    e_a <= pixel_alpha;
  end

  assign is_hsl = (color_mode == MODE_HSL);

  ckar_cone u_pix_cone (
    .clk(clk), .red(e_r), .green(e_g), .blue(e_b), .hsl(is_hsl), .pt(ppt)
  );
  ckar_cone u_key_cone (
    .clk(clk), .red(key_red), .green(key_green), .blue(key_blue), .hsl(is_hsl), .pt(kpt)
  );

  // Pixel bytes and valid bit wait beside the cone pipeline.
  always_ff @(posedge clk) begin
    for (int s = 0; s < CONE_LAT; s++) begin
      if (rst) begin
        dly_vld[s] <= 1'b0;
      end else if (s == 0) begin
        dly_vld[s] <= e_vld;
      end else begin
        dly_vld[s] <= dly_vld[s-1];
      end
      if (s == 0) begin
        dly_r[s] <= e_r;
        dly_g[s] <= e_g;
        dly_b[s] <= e_b;
        dly_a[s] <= e_a;
      end else begin
        dly_r[s] <= dly_r[s-1];
        dly_g[s] <= dly_g[s-1];
        dly_b[s] <= dly_b[s-1];
        dly_a[s] <= dly_a[s-1];
      end
    end
  end

  // Per-axis differences for the chosen space.
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= 1'b0;
    end else begin
      d1_vld <= dly_vld[CONE_LAT-1];
    end
    if (color_mode == MODE_RGB) begin
      d1_dx <= chan_diff(dly_r[CONE_LAT-1], key_red);
      d1_dy <= chan_diff(dly_g[CONE_LAT-1], key_green);
      d1_dz <= chan_diff(dly_b[CONE_LAT-1], key_blue);
    end else begin
      d1_dx <= {kpt.x[17], kpt.x} - {ppt.x[17], ppt.x};
      d1_dy <= {kpt.y[17], kpt.y} - {ppt.y[17], ppt.y};
      d1_dz <= $signed({3'b0, kpt.z}) - $signed({3'b0, ppt.z});
    end
    d1_r <= dly_r[CONE_LAT-1];
    d1_g <= dly_g[CONE_LAT-1];
    d1_b <= dly_b[CONE_LAT-1];
    d1_a <= dly_a[CONE_LAT-1];
  end

  // Squares of the differences.
  assign px2 = d1_dx * d1_dx;
  assign py2 = d1_dy * d1_dy;
  assign pz2 = d1_dz * d1_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_vld <= 1'b0;
    end else begin
      d2_vld <= d1_vld;
    end
    d2_sx <= px2[35:0];
    d2_sy <= py2[35:0];
    d2_sz <= pz2[35:0];
    d2_r  <= d1_r;
    d2_g  <= d1_g;
    d2_b  <= d1_b;
    d2_a  <= d1_a;
  end

  // Sum and compare; the unused mode never matches.
  assign dist_sum = {1'b0, d2_sx} + {1'b0, d2_sy} + {1'b0, d2_sz};
  assign hit      = (color_mode != MODE_OFF) && (dist_sum <= limit);

  // Result registers: one transaction per cycle that done is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_vld;
    end
    out_red   <= d2_r;
    out_green <= d2_g;
    out_blue  <= d2_b;
    out_alpha <= hit ? new_alpha : d2_a;
    matched   <= hit;
  end

  // Every accepted pixel yields its result after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("result did not appear after the pipeline latency");

  // A match carries the configured alpha.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && matched) |-> (out_alpha == new_alpha))
    else $error("matched pixel without replaced alpha");

  // The unused mode never matches.
  a_off: assert property (@(posedge clk) disable iff (rst)
    (done && color_mode == MODE_OFF) |-> !matched)
    else $error("match reported in the unused mode");

  // No result leaves right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

endmodule
